// File: rtl/dhc_pkg.sv
// shared types and constants for the dial homing calibration sequencer
package dhc_pkg;

	localparam int POS_BITS = 16;

	typedef logic [POS_BITS-1:0] pos_t;

	typedef enum logic [1:0] {
		MODE_MANUAL = 2'd0,
		MODE_AUTO   = 2'd1,
		MODE_CAL    = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		PH_NONE   = 3'd0,
		PH_ZERO   = 3'd1,
		PH_SEARCH = 3'd2,
		PH_CHECK  = 3'd3,
		PH_MOVE   = 3'd4,
		PH_DONE   = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		CMD_NONE   = 2'd0,
		CMD_ROTATE = 2'd1,
		CMD_SEEK   = 2'd2,
		CMD_ZERO   = 2'd3
	} cmd_t;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_SET  = 1'b1;

	// revolution setup
	localparam int STEPS_RESET  = 4096;
	localparam int STEPS_MIN    = 40;
	localparam int NUDGE_STEPS  = 10;
	localparam int END_DIVISOR  = 20;
	// x / 5 == (x * RECIP_5) >> RECIP_SHIFT for x below 2**18
	localparam int RECIP_5      = 52429;
	localparam int RECIP_SHIFT  = 18;

	localparam int HI_RESET      = STEPS_RESET - NUDGE_STEPS;
	localparam int NEAR_LO_RESET = STEPS_RESET / END_DIVISOR;
	localparam int NEAR_HI_RESET = STEPS_RESET - STEPS_RESET / END_DIVISOR;
	localparam int HALF_RESET    = STEPS_RESET / 2;

	typedef struct packed {
		pos_t hi;
		pos_t near_lo;
		pos_t near_hi;
		pos_t half;
	} cfg_t;

	typedef struct packed {
		cmd_t   motor_command;
		logic   command_dial;
		pos_t   command_amount;
		mode_t  mode_now;
		phase_t cal_phase;
		pos_t   centre_dial0;
		pos_t   centre_dial1;
		logic   last_of_run;
	} res_t;

	typedef struct packed {
		logic load;
		logic two;
		res_t w0;
		res_t w1;
	} res_pair_t;

endpackage

// File: rtl/dhc_item_if.sv
// input channel carrying one tick or mode command word
interface dhc_item_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [1:0]  requested_mode;
	logic        sensor_dial0;
	logic        sensor_dial1;
	logic [15:0] position_dial0;
	logic [15:0] position_dial1;
	logic        ready_dial0;
	logic        ready_dial1;

	modport source (
		output valid, operation, requested_mode, sensor_dial0, sensor_dial1,
		output position_dial0, position_dial1, ready_dial0, ready_dial1,
		input  ready
	);
	modport sink (
		input  valid, operation, requested_mode, sensor_dial0, sensor_dial1,
		input  position_dial0, position_dial1, ready_dial0, ready_dial1,
		output ready
	);
endinterface

// File: rtl/dhc_result_if.sv
// output channel carrying one motor command and status word
interface dhc_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  motor_command;
	logic        command_dial;
	logic [15:0] command_amount;
	logic [1:0]  mode_now;
	logic [2:0]  cal_phase;
	logic [15:0] centre_dial0;
	logic [15:0] centre_dial1;
	logic        last_of_run;

	modport source (
		output valid, motor_command, command_dial, command_amount, mode_now,
		output cal_phase, centre_dial0, centre_dial1, last_of_run,
		input  ready
	);
	modport sink (
		input  valid, motor_command, command_dial, command_amount, mode_now,
		input  cal_phase, centre_dial0, centre_dial1, last_of_run,
		output ready
	);
endinterface

// File: rtl/dhc_cfg.sv
// revolution register with precomputed search limits and margins
module dhc_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_wdata,
	output dhc_pkg::cfg_t       cfg
);

	logic [15:0] steps;
	logic [31:0] prod;
	logic [15:0] q20;
	dhc_pkg::cfg_t cfg_q;

	always_comb begin
		steps = (cfg_wdata < 16'(dhc_pkg::STEPS_MIN)) ? 16'(dhc_pkg::STEPS_MIN) : cfg_wdata;
		// steps / 20 as (steps / 4) / 5
		prod  = 32'(steps[15:2]) * 32'(dhc_pkg::RECIP_5);
		q20   = 16'(prod >> dhc_pkg::RECIP_SHIFT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hi      <= dhc_pkg::POS_BITS'(dhc_pkg::HI_RESET);
			cfg_q.near_lo <= dhc_pkg::POS_BITS'(dhc_pkg::NEAR_LO_RESET);
			cfg_q.near_hi <= dhc_pkg::POS_BITS'(dhc_pkg::NEAR_HI_RESET);
			cfg_q.half    <= dhc_pkg::POS_BITS'(dhc_pkg::HALF_RESET);
		end else if (cfg_we) begin
			cfg_q.hi      <= steps - 16'(dhc_pkg::NUDGE_STEPS);
			cfg_q.near_lo <= q20;
			cfg_q.near_hi <= steps - q20;
			cfg_q.half    <= {1'b0, steps[15:1]};
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/dhc_core.sv
// input register, calibration state and single pass next-state logic
module dhc_core (
	input  logic                  clk,
	input  logic                  arst_n,
	dhc_item_if.sink              item,
	input  dhc_pkg::cfg_t         cfg,
	input  logic                  load_ok,
	output dhc_pkg::res_pair_t    pair
);

	logic              valid_s1;
	logic              op_s1;
	logic [1:0]        req_s1;
	logic              sens0_s1, sens1_s1;
	dhc_pkg::pos_t     pos0_s1, pos1_s1;
	logic              rdy0_s1, rdy1_s1;

	dhc_pkg::mode_t    mode_q, mode_d, ret_q, ret_d;
	dhc_pkg::phase_t   phase_q, phase_d;
	logic              dial_q, dial_d;
	logic              prev_q, prev_d;
	dhc_pkg::pos_t     first_q [2];
	dhc_pkg::pos_t     first_d [2];
	dhc_pkg::pos_t     last_q [2];
	dhc_pkg::pos_t     last_d [2];
	dhc_pkg::pos_t     centre_q [2];
	dhc_pkg::pos_t     centre_d [2];

	logic              fire;
	logic              idx, sense, rdy;
	dhc_pkg::pos_t     posn;
	logic [1:0]        e_cnt;
	dhc_pkg::cmd_t     c0, c1;
	dhc_pkg::pos_t     a0, a1;
	logic              d_emit;
	logic [dhc_pkg::POS_BITS:0] edge_sum;

	assign fire       = valid_s1 && load_ok;
	assign item.ready = !valid_s1 || load_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			op_s1    <= item.operation;
			req_s1   <= item.requested_mode;
			sens0_s1 <= item.sensor_dial0;
			sens1_s1 <= item.sensor_dial1;
			pos0_s1  <= item.position_dial0;
			pos1_s1  <= item.position_dial1;
			rdy0_s1  <= item.ready_dial0;
			rdy1_s1  <= item.ready_dial1;
		end
	end

	always_comb begin
		mode_d   = mode_q;
		ret_d    = ret_q;
		phase_d  = phase_q;
		dial_d   = dial_q;
		prev_d   = prev_q;
		first_d  = first_q;
		last_d   = last_q;
		centre_d = centre_q;
		e_cnt    = 2'd0;
		c0       = dhc_pkg::CMD_NONE;
		c1       = dhc_pkg::CMD_NONE;
		a0       = '0;
		a1       = '0;
		d_emit   = dial_q;
		idx      = dial_q;
		sense    = idx ? sens1_s1 : sens0_s1;
		rdy      = idx ? rdy1_s1 : rdy0_s1;
		posn     = idx ? pos1_s1 : pos0_s1;
		edge_sum = {1'b0, first_q[idx]} + {1'b0, last_q[idx]};

		if (op_s1 == dhc_pkg::OP_SET) begin
			if (req_s1 == dhc_pkg::MODE_CAL) begin
				if (mode_q != dhc_pkg::MODE_CAL) ret_d = mode_q;
				mode_d     = dhc_pkg::MODE_CAL;
				dial_d     = 1'b0;
				phase_d    = dhc_pkg::PH_ZERO;
				first_d[0] = '0;
				last_d[0]  = '0;
				e_cnt      = 2'd1;
				c0         = dhc_pkg::CMD_ROTATE;
				a0         = dhc_pkg::POS_BITS'(dhc_pkg::NUDGE_STEPS);
				d_emit     = 1'b0;
			end else if (req_s1 == dhc_pkg::MODE_MANUAL || req_s1 == dhc_pkg::MODE_AUTO) begin
				mode_d = dhc_pkg::mode_t'(req_s1);
			end
		end else if (mode_q == dhc_pkg::MODE_CAL) begin
			case (phase_q)
				dhc_pkg::PH_ZERO: begin
					if (rdy) begin
						phase_d = dhc_pkg::PH_SEARCH;
						prev_d  = sense;
						e_cnt   = 2'd1;
						c0      = dhc_pkg::CMD_SEEK;
						a0      = cfg.hi;
					end
				end
				dhc_pkg::PH_SEARCH: begin
					if (posn == cfg.hi) begin
						phase_d = dhc_pkg::PH_CHECK;
					end else begin
						// a zero first edge means none seen yet
						if (sense != prev_q) begin
							if (first_q[idx] == '0) begin
								if (!sense) first_d[idx] = posn;
							end else if (sense) begin
								last_d[idx] = posn;
							end
						end
						prev_d = sense;
					end
				end
				dhc_pkg::PH_CHECK: begin
					if (first_q[idx] < cfg.near_lo || first_q[idx] > cfg.near_hi ||
					    last_q[idx] < cfg.near_lo || last_q[idx] > cfg.near_hi) begin
						phase_d = dhc_pkg::PH_MOVE;
						e_cnt   = 2'd1;
						c0      = dhc_pkg::CMD_SEEK;
						a0      = cfg.half;
					end else begin
						phase_d = dhc_pkg::PH_DONE;
					end
				end
				dhc_pkg::PH_MOVE: begin
					// recentred: re-zero then nudge again
					if (posn == cfg.half) begin
						phase_d      = dhc_pkg::PH_ZERO;
						first_d[idx] = '0;
						last_d[idx]  = '0;
						e_cnt        = 2'd2;
						c0           = dhc_pkg::CMD_ZERO;
						c1           = dhc_pkg::CMD_ROTATE;
						a1           = dhc_pkg::POS_BITS'(dhc_pkg::NUDGE_STEPS);
					end
				end
				dhc_pkg::PH_DONE: begin
					centre_d[idx] = edge_sum[dhc_pkg::POS_BITS:1];
					if (idx == 1'b0) begin
						dial_d     = 1'b1;
						phase_d    = dhc_pkg::PH_ZERO;
						first_d[1] = '0;
						last_d[1]  = '0;
						e_cnt      = 2'd1;
						c0         = dhc_pkg::CMD_ROTATE;
						a0         = dhc_pkg::POS_BITS'(dhc_pkg::NUDGE_STEPS);
						d_emit     = 1'b1;
					end else begin
						dial_d  = 1'b0;
						phase_d = dhc_pkg::PH_NONE;
						mode_d  = ret_q;
					end
				end
				default: begin
				end
			endcase
		end

		pair.load                 = fire;
		pair.two                  = (e_cnt == 2'd2);
		pair.w0.motor_command     = c0;
		pair.w0.command_dial      = (e_cnt == 2'd0) ? dial_d : d_emit;
		pair.w0.command_amount    = a0;
		pair.w0.mode_now          = mode_d;
		pair.w0.cal_phase         = phase_d;
		pair.w0.centre_dial0      = centre_d[0];
		pair.w0.centre_dial1      = centre_d[1];
		pair.w0.last_of_run       = (e_cnt != 2'd2);
		pair.w1                   = pair.w0;
		pair.w1.motor_command     = c1;
		pair.w1.command_amount    = a1;
		pair.w1.last_of_run       = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= dhc_pkg::MODE_CAL;
			ret_q       <= dhc_pkg::MODE_AUTO;
			phase_q     <= dhc_pkg::PH_ZERO;
			dial_q      <= 1'b0;
			prev_q      <= 1'b0;
			first_q[0]  <= '0;
			first_q[1]  <= '0;
			last_q[0]   <= '0;
			last_q[1]   <= '0;
			centre_q[0] <= '0;
			centre_q[1] <= '0;
		end else if (fire) begin
			mode_q   <= mode_d;
			ret_q    <= ret_d;
			phase_q  <= phase_d;
			dial_q   <= dial_d;
			prev_q   <= prev_d;
			first_q  <= first_d;
			last_q   <= last_d;
			centre_q <= centre_d;
		end
	end

	// re-zero pair is always zero then rotate on one dial
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		pair.load && pair.two |-> pair.w0.motor_command == dhc_pkg::CMD_ZERO &&
			pair.w1.motor_command == dhc_pkg::CMD_ROTATE &&
			pair.w0.command_dial == pair.w1.command_dial)
		else $error("re-zero command pair out of order");

	// idle phase is only reached after the second dial
	a_idle_dial: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == dhc_pkg::PH_NONE |-> dial_q == 1'b0)
		else $error("idle phase with dial one selected");

endmodule

// File: rtl/dhc_outbuf.sv
// result register with a second slot for the re-zero pair
module dhc_outbuf (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dhc_pkg::res_pair_t    pair,
	output logic                  load_ok,
	dhc_result_if.source          result
);

	logic          o_valid_q;
	logic          sec_valid_q;
	dhc_pkg::res_t o_word_q;
	dhc_pkg::res_t sec_word_q;
	logic          take;

	assign take    = o_valid_q && result.ready;
	assign load_ok = !sec_valid_q && (!o_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q   <= 1'b0;
			sec_valid_q <= 1'b0;
		end else if (pair.load) begin
			o_valid_q   <= 1'b1;
			sec_valid_q <= pair.two;
		end else if (take) begin
			if (sec_valid_q) sec_valid_q <= 1'b0;
			else o_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pair.load) begin
			o_word_q   <= pair.w0;
			sec_word_q <= pair.w1;
		end else if (take && sec_valid_q) begin
			o_word_q <= sec_word_q;
		end
	end

	assign result.valid          = o_valid_q;
	assign result.motor_command  = o_word_q.motor_command;
	assign result.command_dial   = o_word_q.command_dial;
	assign result.command_amount = o_word_q.command_amount;
	assign result.mode_now       = o_word_q.mode_now;
	assign result.cal_phase      = o_word_q.cal_phase;
	assign result.centre_dial0   = o_word_q.centre_dial0;
	assign result.centre_dial1   = o_word_q.centre_dial1;
	assign result.last_of_run    = o_word_q.last_of_run;

	a_sec_behind: assert property (@(posedge clk) disable iff (!arst_n)
		sec_valid_q |-> o_valid_q)
		else $error("second slot full while result register empty");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		pair.load |-> !sec_valid_q)
		else $error("new word loaded over a pending second word");

	a_pair_tail: assert property (@(posedge clk) disable iff (!arst_n)
		sec_valid_q |-> !o_word_q.last_of_run)
		else $error("first word of a pair marked as last");

endmodule

// File: rtl/dial_homing_calibration_sequencer.sv
// Dial homing calibration sequencer: two-dial opto calibration with motor commands.
// The first result word passes the input register, then the output register.
// Throughput: one input word per cycle while result.ready holds; a re-zero step
// gives two result words, and the next input waits until the second is taken.
// Reset (arst_n low, asynchronous): calibrate mode, dial zero in the zero phase,
// edges and centres cleared, revolution set to 4096 steps.
module dial_homing_calibration_sequencer (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [15:0]   cfg_wdata,
	dhc_item_if.sink      item,
	dhc_result_if.source  result
);

	dhc_pkg::cfg_t      cfg;
	dhc_pkg::res_pair_t pair;
	logic               load_ok;

	dhc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	dhc_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.cfg     (cfg),
		.load_ok (load_ok),
		.pair    (pair)
	);

	dhc_outbuf u_outbuf (
		.clk     (clk),
		.arst_n  (arst_n),
		.pair    (pair),
		.load_ok (load_ok),
		.result  (result)
	);

endmodule
